[src/sgws_pkg.sv]
// ----------------------------------------------------------------------------
// sgws_pkg: shared definitions for the soft grid word search
// Sizes, store address maps, codes and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none
package sgws_pkg;

   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLS    = 32;
   localparam int MAX_WORD    = 16;
   localparam int NUM_CLASSES = 26;

   localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS * NUM_CLASSES;
   localparam int WORD_DEPTH = MAX_WORD * NUM_CLASSES;
   localparam int LS_DEPTH   = MAX_ROWS * MAX_COLS * MAX_WORD;
   localparam int GRID_AW    = $clog2(GRID_DEPTH);
   localparam int WORD_AW    = $clog2(WORD_DEPTH);
   localparam int LS_AW      = $clog2(LS_DEPTH);

   localparam int LOG_W   = 16;
   localparam int PROB_W  = 16;
   localparam int LS_W    = 36;
   localparam int SCORE_W = 41;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;

   // ln 2 in unsigned Q.26
   localparam logic [25:0] LN2_Q26 = 26'd46516320;

   typedef enum logic [1:0] {
      FUNC_GRID   = 2'd0,
      FUNC_WORD   = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   typedef struct packed {
      logic [1:0]        func;
      logic [4:0]        cell_row;
      logic [4:0]        cell_col;
      logic [3:0]        letter_pos;
      logic [4:0]        class_index;
      logic [PROB_W-1:0] prob;
      logic [4:0]        word_length;
   } req_type;

   typedef struct packed {
      logic [5:0] rows_in_use;
      logic [5:0] cols_in_use;
   } cfg_type;

   typedef struct packed {
      logic                      found;
      logic [4:0]                start_row;
      logic [4:0]                start_col;
      logic [2:0]                direction;
      logic signed [SCORE_W-1:0] path_score;
   } result_type;

   typedef struct packed {
      logic               we;
      logic [GRID_AW-1:0] waddr;
      logic [LOG_W-1:0]   wdata;
      logic [GRID_AW-1:0] raddr;
   } grid_port_type;

   typedef struct packed {
      logic               we;
      logic [WORD_AW-1:0] waddr;
      logic [PROB_W-1:0]  wdata;
      logic [WORD_AW-1:0] raddr;
   } word_port_type;

   typedef struct packed {
      logic             we;
      logic [LS_AW-1:0] waddr;
      logic [LS_W-1:0]  wdata;
      logic [LS_AW-1:0] raddr;
   } ls_port_type;

   typedef struct packed {
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_op_type;

   function automatic logic [GRID_AW-1:0] grid_addr(input logic [4:0] r,
                                                    input logic [4:0] c,
                                                    input logic [4:0] cl);
      grid_addr = GRID_AW'((int'(r) * MAX_COLS + int'(c)) * NUM_CLASSES + int'(cl));
   endfunction

   function automatic logic [WORD_AW-1:0] word_addr(input logic [3:0] k,
                                                    input logic [4:0] cl);
      word_addr = WORD_AW'(int'(k) * NUM_CLASSES + int'(cl));
   endfunction

   function automatic logic [LS_AW-1:0] ls_addr(input logic [4:0] r,
                                                input logic [4:0] c,
                                                input logic [3:0] k);
      ls_addr = LS_AW'((int'(r) * MAX_COLS + int'(c)) * MAX_WORD + int'(k));
   endfunction

   // row step of each direction
   function automatic logic signed [1:0] dir_dr(input logic [2:0] d);
      case (d)
         3'd2, 3'd4, 3'd5: dir_dr = 2'sd1;
         3'd3, 3'd6, 3'd7: dir_dr = -2'sd1;
         default:          dir_dr = 2'sd0;
      endcase
   endfunction

   // column step of each direction
   function automatic logic signed [1:0] dir_dc(input logic [2:0] d);
      case (d)
         3'd0, 3'd4, 3'd6: dir_dc = 2'sd1;
         3'd1, 3'd5, 3'd7: dir_dc = -2'sd1;
         default:          dir_dc = 2'sd0;
      endcase
   endfunction

endpackage
`default_nettype wire

[src/soft_grid_word_search.sv]
// ----------------------------------------------------------------------------
// soft_grid_word_search: soft word search over a grid of letter probabilities
//
// Requests arrive on the req_ stream; req_tuser selects the function.
// A word probability load is written to its store as it is taken. A grid
// probability load is turned into a Q5.10 natural log before it is stored:
// 32 squaring steps on the shared multiplier, each squaring and then
// renormalizing, followed by the scaling states S_LOG_M1 and S_LOG_M2.
// A search request yields one response on the rsp_ stream. It forms the
// letter scores, a multiply-accumulate on the shared multiplier for each
// cell, letter and class, then makes rows * cols * 8 fit checks and sums
// each path that fits before comparing it with the best so far. Loads
// produce no response; an unused function code is dropped. The finished
// response sits in an output register, so the next request is taken while
// rsp_tready is low; a second search waits at its end until that register
// frees up. The user writes rows_in_use and cols_in_use through csr_ only
// while idle; the block does not enforce this. Reset clears control state
// and sets both to 32; the stores are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module soft_grid_word_search (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // cell_row, cell_col, letter_pos, class_index, prob, word_length
   input  wire logic [39:0]                      req_tdata,
   // func
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // start_row, start_col, direction, path_score, zero fill
   output logic [55:0]                           rsp_tdata,
   // found
   output logic                                  rsp_tuser,
   input  wire logic                             csr_we,
   input  wire logic [sgws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [5:0]                       csr_wdata
);
   import sgws_pkg::*;

   req_type                  req;
   cfg_type                  cfg;
   grid_port_type            grid_port;
   word_port_type            word_port;
   ls_port_type              ls_port;
   mul_op_type               mul_op;
   logic signed [PROD_W-1:0] mul_prod;
   logic [LOG_W-1:0]         grid_rd;
   logic [PROB_W-1:0]        word_rd;
   logic [LS_W-1:0]          ls_rd;
   logic                     res_valid;
   logic                     res_taken;
   result_type               res;

   logic [5:0]  rows_ff, cols_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   assign req.func        = req_tuser;
   assign req.cell_row    = req_tdata[4:0];
   assign req.cell_col    = req_tdata[9:5];
   assign req.letter_pos  = req_tdata[13:10];
   assign req.class_index = req_tdata[18:14];
   assign req.prob        = req_tdata[34:19];
   assign req.word_length = req_tdata[39:35];

   assign cfg.rows_in_use = rows_ff;
   assign cfg.cols_in_use = cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 6'(MAX_ROWS);
         cols_ff <= 6'(MAX_COLS);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata;
            CSR_COLS: cols_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   sgws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req       (req),
      .req_ready (req_tready),
      .cfg       (cfg),
      .grid_port (grid_port),
      .grid_rd   (grid_rd),
      .word_port (word_port),
      .word_rd   (word_rd),
      .ls_port   (ls_port),
      .ls_rd     (ls_rd),
      .mul_op    (mul_op),
      .mul_prod  (mul_prod),
      .res_valid (res_valid),
      .res       (res),
      .res_taken (res_taken)
   );

   sgws_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (mul_prod)
   );

   sgws_ram #(.WIDTH(LOG_W), .DEPTH(GRID_DEPTH)) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_port.we),
      .wr_addr (grid_port.waddr),
      .wr_data (grid_port.wdata),
      .rd_addr (grid_port.raddr),
      .rd_data (grid_rd)
   );

   sgws_ram #(.WIDTH(PROB_W), .DEPTH(WORD_DEPTH)) u_word_ram (
      .clock   (clock),
      .wr_en   (word_port.we),
      .wr_addr (word_port.waddr),
      .wr_data (word_port.wdata),
      .rd_addr (word_port.raddr),
      .rd_data (word_rd)
   );

   sgws_ram #(.WIDTH(LS_W), .DEPTH(LS_DEPTH)) u_ls_ram (
      .clock   (clock),
      .wr_en   (ls_port.we),
      .wr_addr (ls_port.waddr),
      .wr_data (ls_port.wdata),
      .rd_addr (ls_port.raddr),
      .rd_data (ls_rd)
   );

   // output register frees the sequencer while the receiver stalls
   assign res_taken = res_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_taken) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_taken) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.found;
   assign rsp_tdata  = {2'b00, rsp_ff.path_score, rsp_ff.direction,
                        rsp_ff.start_col, rsp_ff.start_row};
endmodule
`default_nettype wire

[src/sgws_ram.sv]
// ----------------------------------------------------------------------------
// sgws_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sgws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[src/sgws_mul.sv]
// ----------------------------------------------------------------------------
// sgws_mul: shared signed multiplier
// 33 x 33 signed product, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module sgws_mul (
   input  wire logic                              clock,
   input  wire sgws_pkg::mul_op_type              op,
   output logic signed [sgws_pkg::PROD_W-1:0]     prod
);
   import sgws_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op.a * op.b;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

[src/sgws_ctrl.sv]
// ----------------------------------------------------------------------------
// sgws_ctrl: sequencer for loads, log conversion and the search scan
// Drives the stores and the shared multiplier one step at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module sgws_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire sgws_pkg::req_type               req,
   output logic                                 req_ready,
   input  wire sgws_pkg::cfg_type               cfg,
   output sgws_pkg::grid_port_type              grid_port,
   input  wire logic [sgws_pkg::LOG_W-1:0]      grid_rd,
   output sgws_pkg::word_port_type              word_port,
   input  wire logic [sgws_pkg::PROB_W-1:0]     word_rd,
   output sgws_pkg::ls_port_type                ls_port,
   input  wire logic [sgws_pkg::LS_W-1:0]       ls_rd,
   output sgws_pkg::mul_op_type                 mul_op,
   input  wire logic signed [sgws_pkg::PROD_W-1:0] mul_prod,
   output logic                                 res_valid,
   output sgws_pkg::result_type                 res,
   input  wire logic                            res_taken
);
   import sgws_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_LOG_SQ  = 13'b0000000000010,
      S_LOG_UPD = 13'b0000000000100,
      S_LOG_M1  = 13'b0000000001000,
      S_LOG_M2  = 13'b0000000010000,
      S_LS_ADDR = 13'b0000000100000,
      S_LS_MUL  = 13'b0000001000000,
      S_LS_ACC  = 13'b0000010000000,
      S_PS_FIT  = 13'b0000100000000,
      S_PS_ADDR = 13'b0001000000000,
      S_PS_ACC  = 13'b0010000000000,
      S_PS_CMP  = 13'b0100000000000,
      S_DONE    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]               m_ff, m_in;
   logic [31:0]               frac_ff, frac_in;
   logic [4:0]                iter_ff, iter_in;
   logic [3:0]                msb_ff, msb_in;
   logic [4:0]                neg_hi_ff, neg_hi_in;
   logic [GRID_AW-1:0]        gaddr_ff, gaddr_in;
   logic [4:0]                len_ff, len_in;
   logic [5:0]                rows_ff, rows_in;
   logic [5:0]                cols_ff, cols_in;
   logic [4:0]                r_ff, r_in;
   logic [4:0]                c_ff, c_in;
   logic [3:0]                k_ff, k_in;
   logic [4:0]                cl_ff, cl_in;
   logic [2:0]                d_ff, d_in;
   logic [4:0]                rr_ff, rr_in;
   logic [4:0]                cc_ff, cc_in;
   logic signed [LS_W-1:0]    acc_ff, acc_in;
   logic signed [SCORE_W-1:0] sum_ff, sum_in;
   logic signed [SCORE_W-1:0] best_ff, best_in;
   logic                      have_ff, have_in;
   logic [4:0]                br_ff, br_in;
   logic [4:0]                bc_ff, bc_in;
   logic [2:0]                bd_ff, bd_in;

   // comb helpers
   logic [PROB_W-1:0]         p_clamp;
   logic [3:0]                p_msb;
   logic [32:0]               sq;
   logic [36:0]               neg;
   logic [63:0]               log_total;
   logic [15:0]               log_mag;
   logic signed [LS_W-1:0]    acc_next;
   logic [3:0]                lm1;
   logic signed [6:0]         end_r, end_c;
   logic                      fits;
   logic signed [1:0]         dr, dc;
   logic                      ps_next;
   logic                      last_k, last_c, last_r;

   function automatic logic signed [6:0] path_end(input logic [4:0] pos,
                                                  input logic signed [1:0] step,
                                                  input logic [3:0] span);
      case (step)
         2'sd1:   path_end = $signed({2'b00, pos}) + $signed({3'b000, span});
         -2'sd1:  path_end = $signed({2'b00, pos}) - $signed({3'b000, span});
         default: path_end = $signed({2'b00, pos});
      endcase
   endfunction

   function automatic logic [4:0] msb_neg_term(input logic [3:0] msb);
      msb_neg_term = 5'd16 - {1'b0, msb};
   endfunction

   always_comb begin
      p_clamp = (req.prob == '0) ? PROB_W'(1) : req.prob;
      p_msb   = '0;
      for (int i = 0; i < PROB_W; i++) begin
         if (p_clamp[i]) begin
            p_msb = 4'(i);
         end
      end
   end

   assign sq        = mul_prod[63:31];
   assign neg       = {msb_neg_term(msb_ff), 32'd0} - {5'd0, frac_ff};
   assign log_total = $unsigned(mul_prod[63:0])
                    + ((64'(neg_hi_ff) * 64'(LN2_Q26)) << 32)
                    + (64'd1 << 47);
   assign log_mag   = log_total[63:48];
   assign acc_next  = acc_ff + $signed(mul_prod[LS_W-1:0]);
   assign lm1       = 4'(len_ff - 5'd1);
   assign dr        = dir_dr(d_ff);
   assign dc        = dir_dc(d_ff);
   assign end_r     = path_end(r_ff, dr, lm1);
   assign end_c     = path_end(c_ff, dc, lm1);
   assign fits      = !end_r[6] && (end_r < $signed({1'b0, rows_ff}))
                   && !end_c[6] && (end_c < $signed({1'b0, cols_ff}));
   assign last_k    = ({1'b0, k_ff} == len_ff - 5'd1);
   assign last_c    = ({1'b0, c_ff} == cols_ff - 6'd1);
   assign last_r    = ({1'b0, r_ff} == rows_ff - 6'd1);

   always_comb begin
      state_in  = state_ff;
      m_in      = m_ff;
      frac_in   = frac_ff;
      iter_in   = iter_ff;
      msb_in    = msb_ff;
      neg_hi_in = neg_hi_ff;
      gaddr_in  = gaddr_ff;
      len_in    = len_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      cl_in     = cl_ff;
      d_in      = d_ff;
      rr_in     = rr_ff;
      cc_in     = cc_ff;
      acc_in    = acc_ff;
      sum_in    = sum_ff;
      best_in   = best_ff;
      have_in   = have_ff;
      br_in     = br_ff;
      bc_in     = bc_ff;
      bd_in     = bd_ff;
      ps_next   = 1'b0;

      grid_port.we    = 1'b0;
      grid_port.waddr = gaddr_ff;
      grid_port.wdata = ~log_mag + 16'd1;
      grid_port.raddr = grid_addr(r_ff, c_ff, cl_ff);
      word_port.we    = 1'b0;
      word_port.waddr = word_addr(req.letter_pos, req.class_index);
      word_port.wdata = req.prob;
      word_port.raddr = word_addr(k_ff, cl_ff);
      ls_port.we      = 1'b0;
      ls_port.waddr   = ls_addr(r_ff, c_ff, k_ff);
      ls_port.wdata   = acc_next;
      ls_port.raddr   = ls_addr(rr_ff, cc_ff, k_ff);
      mul_op.a        = '0;
      mul_op.b        = '0;
      res_valid       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (func_type'(req.func))
                  FUNC_GRID: begin
                     if (int'(req.class_index) < NUM_CLASSES
                         && int'(req.cell_row) < MAX_ROWS
                         && int'(req.cell_col) < MAX_COLS) begin
                        msb_in   = p_msb;
                        m_in     = 32'(p_clamp) << (5'd31 - {1'b0, p_msb});
                        frac_in  = '0;
                        iter_in  = '0;
                        gaddr_in = grid_addr(req.cell_row, req.cell_col, req.class_index);
                        state_in = S_LOG_SQ;
                     end
                  end
                  FUNC_WORD: begin
                     if (int'(req.class_index) < NUM_CLASSES
                         && int'(req.letter_pos) < MAX_WORD) begin
                        word_port.we = 1'b1;
                     end
                  end
                  FUNC_SEARCH: begin
                     len_in  = req.word_length;
                     rows_in = (int'(cfg.rows_in_use) > MAX_ROWS) ? 6'(MAX_ROWS)
                                                                 : cfg.rows_in_use;
                     cols_in = (int'(cfg.cols_in_use) > MAX_COLS) ? 6'(MAX_COLS)
                                                                 : cfg.cols_in_use;
                     r_in    = '0;
                     c_in    = '0;
                     k_in    = '0;
                     cl_in   = '0;
                     d_in    = '0;
                     acc_in  = '0;
                     have_in = 1'b0;
                     best_in = '0;
                     br_in   = '0;
                     bc_in   = '0;
                     bd_in   = '0;
                     if (req.word_length != 5'd0 && int'(req.word_length) <= MAX_WORD
                         && rows_in != 6'd0 && cols_in != 6'd0) begin
                        state_in = S_LS_ADDR;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOG_SQ: begin
            mul_op.a = {1'b0, m_ff};
            mul_op.b = {1'b0, m_ff};
            state_in = S_LOG_UPD;
         end
         S_LOG_UPD: begin
            // renormalize the square back into [1, 2)
            m_in    = sq[32] ? sq[32:1] : sq[31:0];
            frac_in = {frac_ff[30:0], sq[32]};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd31) begin
               state_in = S_LOG_M1;
            end else begin
               state_in = S_LOG_SQ;
            end
         end
         S_LOG_M1: begin
            mul_op.a  = {1'b0, neg[31:0]};
            mul_op.b  = MUL_W'(LN2_Q26);
            neg_hi_in = neg[36:32];
            state_in  = S_LOG_M2;
         end
         S_LOG_M2: begin
            grid_port.we = 1'b1;
            state_in     = S_IDLE;
         end
         S_LS_ADDR: begin
            state_in = S_LS_MUL;
         end
         S_LS_MUL: begin
            mul_op.a = {17'd0, word_rd};
            mul_op.b = {{17{grid_rd[LOG_W-1]}}, grid_rd};
            state_in = S_LS_ACC;
         end
         S_LS_ACC: begin
            state_in = S_LS_ADDR;
            if (int'(cl_ff) == NUM_CLASSES - 1) begin
               ls_port.we = 1'b1;
               acc_in     = '0;
               cl_in      = '0;
               if (last_k) begin
                  k_in = '0;
                  if (last_c) begin
                     c_in = '0;
                     if (last_r) begin
                        r_in     = '0;
                        d_in     = '0;
                        state_in = S_PS_FIT;
                     end else begin
                        r_in = r_ff + 5'd1;
                     end
                  end else begin
                     c_in = c_ff + 5'd1;
                  end
               end else begin
                  k_in = k_ff + 4'd1;
               end
            end else begin
               cl_in  = cl_ff + 5'd1;
               acc_in = acc_next;
            end
         end
         S_PS_FIT: begin
            if (fits) begin
               k_in     = '0;
               rr_in    = r_ff;
               cc_in    = c_ff;
               sum_in   = '0;
               state_in = S_PS_ADDR;
            end else begin
               ps_next = 1'b1;
            end
         end
         S_PS_ADDR: begin
            state_in = S_PS_ACC;
         end
         S_PS_ACC: begin
            sum_in = sum_ff + SCORE_W'($signed(ls_rd));
            if (last_k) begin
               state_in = S_PS_CMP;
            end else begin
               k_in     = k_ff + 4'd1;
               rr_in    = rr_ff + {{3{dr[1]}}, dr};
               cc_in    = cc_ff + {{3{dc[1]}}, dc};
               state_in = S_PS_ADDR;
            end
         end
         S_PS_CMP: begin
            if (!have_ff || sum_ff > best_ff) begin
               have_in = 1'b1;
               best_in = sum_ff;
               br_in   = r_ff;
               bc_in   = c_ff;
               bd_in   = d_ff;
            end
            ps_next = 1'b1;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // next start cell and direction of the path scan
      if (ps_next) begin
         state_in = S_PS_FIT;
         if (d_ff == 3'd7) begin
            d_in = '0;
            if (last_c) begin
               c_in = '0;
               if (last_r) begin
                  state_in = S_DONE;
               end else begin
                  r_in = r_ff + 5'd1;
               end
            end else begin
               c_in = c_ff + 5'd1;
            end
         end else begin
            d_in = d_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         have_ff  <= have_in;
      end
      m_ff      <= m_in;
      frac_ff   <= frac_in;
      iter_ff   <= iter_in;
      msb_ff    <= msb_in;
      neg_hi_ff <= neg_hi_in;
      gaddr_ff  <= gaddr_in;
      len_ff    <= len_in;
      rows_ff   <= rows_in;
      cols_ff   <= cols_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      k_ff      <= k_in;
      cl_ff     <= cl_in;
      d_ff      <= d_in;
      rr_ff     <= rr_in;
      cc_ff     <= cc_in;
      acc_ff    <= acc_in;
      sum_ff    <= sum_in;
      best_ff   <= best_in;
      br_ff     <= br_in;
      bc_ff     <= bc_in;
      bd_ff     <= bd_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign res.found      = have_ff;
   assign res.start_row  = br_ff;
   assign res.start_col  = bc_ff;
   assign res.direction  = bd_ff;
   assign res.path_score = best_ff;
endmodule
`default_nettype wire
